>>> rtl/epve_pkg.sv
// Shared widths, codes and types of the encoder period velocity estimator.
package epve_pkg;

    // Calibration table
    localparam int CAL_DEPTH = 16;
    localparam int CAL_IW    = (CAL_DEPTH > 1) ? $clog2(CAL_DEPTH) : 1;
    localparam int LEN_W     = (CAL_IW + 1 > 5) ? CAL_IW + 1 : 5;
    localparam int CAL_W     = 16;
    localparam int CAL_FRAC  = 14;
    localparam logic [CAL_W-1:0] CAL_ONE = CAL_W'(1 << CAL_FRAC);

    // Datapath widths
    localparam int NUM_W  = 48;
    localparam int DEN_W  = 32;
    localparam int VEL_W  = 32;
    localparam int TIME_W = 32;
    localparam int TOC_W  = 5;
    localparam int PROD_W = NUM_W + CAL_W;

    // Configuration register indexes
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_NUMERATOR  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_MAX_INTVL  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_MIN_VEL    = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_VARIANCE   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_CAL_LENGTH = 3'd4;

    // Item function codes
    localparam logic FUNC_STEP      = 1'b0;
    localparam logic FUNC_CAL_WRITE = 1'b1;

    // Result kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_EDGE     = 2'd0;
    localparam t_kind KIND_OVERLONG = 2'd1;
    localparam t_kind KIND_TIMEOUT  = 2'd2;

    typedef logic [CAL_W-1:0] t_cal;
    typedef logic [NUM_W-1:0] t_num;
    typedef logic [DEN_W-1:0] t_den;
    typedef logic [VEL_W-1:0] t_vel;

endpackage

>>> rtl/epve_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module epve_divider (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  epve_pkg::t_num i_numerator,
    input  epve_pkg::t_den i_divisor,
    output logic           o_done,
    output epve_pkg::t_num o_quotient
);
    import epve_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_num             r_num;     // numerator bits shift out, quotient bits shift in
    t_den             r_den;
    t_den             r_rem;

    logic [DEN_W:0]   w_trial;
    logic             w_ge;
    logic [DEN_W:0]   w_diff;

    always_comb begin
        w_trial = {r_rem, r_num[NUM_W-1]};
        w_ge    = w_trial >= {1'b0, r_den};
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_numerator;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            // Remainder stays below the divisor, so it fits the divisor width
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_num;

endmodule

>>> rtl/epve_multiplier.sv
// Bit-serial shift-add multiplier for the calibration factor, with saturation.
module epve_multiplier (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  epve_pkg::t_num i_raw,
    input  epve_pkg::t_cal i_cal,
    output logic           o_done,
    output epve_pkg::t_vel o_velocity
);
    import epve_pkg::*;

    localparam int CNT_W = $clog2(CAL_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    t_num              r_raw;
    t_cal              r_cal;
    logic [PROD_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(CAL_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Most significant factor bit first: double and add
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_raw <= i_raw;
            r_cal <= i_cal;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[PROD_W-2:0], 1'b0}
                     + (r_cal[CAL_W-1] ? PROD_W'(r_raw) : PROD_W'(0));
            r_cal <= {r_cal[CAL_W-2:0], 1'b0};
        end
    end

    always_comb begin
        if (r_acc[PROD_W-1:VEL_W+CAL_FRAC] != '0) begin
            o_velocity = '1;
        end else begin
            o_velocity = r_acc[VEL_W+CAL_FRAC-1:CAL_FRAC];
        end
    end

    assign o_done = r_done;

endmodule

>>> rtl/encoder_period_velocity_estimator_core.sv
// Top level of the encoder period velocity estimator.
//
// Usage: the input channel (i_in_valid / o_in_stall) takes one item per
// handshake: a time step carrying the sampled pin level, or a calibration
// table write. The output channel (o_out_valid / i_out_stall) delivers at most
// one estimate per item from a single output register. The configuration
// channel (i_cfg_valid / o_cfg_ready) is always ready; write it only while
// the block is idle.
// Flow: a time step without a rising edge, and a table write, needs no
// serial work; a timeout or overlong-period estimate shows on the output in
// the next cycle, and such items can follow every cycle while the receiver
// does not stall. A rising edge with a valid period runs the bit-serial
// divider and then the bit-serial multiplier, and no new item is taken
// until its estimate is in the output register.
// Reset: synchronous and active low; clears all counters, loads the default
// registers and fills the calibration table with 1.0.
// Stall: while the output register holds an estimate that the receiver
// stalls, no new item is taken; the estimate and its fields hold.
module encoder_period_velocity_estimator_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input items
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_func,
    input  logic                         i_pin_level,
    input  logic [3:0]                   i_cal_index,
    input  epve_pkg::t_cal               i_cal_value,
    // Result items
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output epve_pkg::t_kind              o_kind,
    output epve_pkg::t_vel               o_velocity,
    output logic [31:0]                  o_variance_out,
    output logic [epve_pkg::TIME_W-1:0]  o_sample_time,
    // Configuration writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [epve_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [epve_pkg::NUM_W-1:0]   i_cfg_data
);
    import epve_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;

    // Configuration registers
    t_num              r_numerator;
    logic [31:0]       r_max_interval;
    t_vel              r_min_vel_half;
    logic [31:0]       r_variance;
    logic [4:0]        r_cal_length;

    // Block state
    logic [1:0]        r_state,       n_state;
    logic              r_prev,        n_prev;
    logic [TIME_W-1:0] r_now,         n_now;
    logic [TIME_W-1:0] r_last_edge,   n_last_edge;
    logic [31:0]       r_since,       n_since;
    logic [TOC_W-1:0]  r_timeouts,    n_timeouts;
    logic [CAL_IW-1:0] r_cal_pos,     n_cal_pos;
    t_cal              r_cal_table [CAL_DEPTH];
    t_cal              r_cal_val;

    // Output register
    logic              r_out_valid,   n_out_valid;
    t_kind             r_out_kind,    n_out_kind;
    t_vel              r_out_vel,     n_out_vel;
    logic [31:0]       r_out_var,     n_out_var;
    logic [TIME_W-1:0] r_out_time,    n_out_time;

    logic              w_in_accept;
    logic [TIME_W-1:0] w_now;
    logic              w_change;
    logic              w_rising;
    logic [TIME_W-1:0] w_interval;
    logic              w_overlong;
    logic [31:0]       w_half_max;
    logic [LEN_W-1:0]  w_len;
    logic [LEN_W-1:0]  w_pos;
    logic [LEN_W-1:0]  w_pos_inc;
    logic [31:0]       w_since_inc;
    logic              w_timeout;
    logic [5:0]        w_shift;
    logic [31:0]       w_var_shifted;
    logic [LEN_W-1:0]  w_wr_idx;
    logic              w_tab_we;
    logic              w_div_start;
    logic              w_div_done;
    t_num              w_quotient;
    logic              w_mul_done;
    t_vel              w_mul_vel;

    // Hold off new items while an edge is being worked out, or while a
    // stalled estimate still sits in the output register
    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Time-step arithmetic, all on the state before this item
    always_comb begin
        w_now      = r_now + TIME_W'(1);
        w_change   = i_pin_level != r_prev;
        w_rising   = w_change && i_pin_level;
        w_interval = w_now - r_last_edge;
        // A period that wraps to zero counts as overlong
        w_overlong = (w_interval == '0)
                     || ({1'b0, w_interval} > {r_max_interval, 1'b0});
        w_half_max = r_max_interval >> 1;

        // Clamp the table length in use to one .. CAL_DEPTH
        if (r_cal_length == '0) begin
            w_len = LEN_W'(1);
        end else if (LEN_W'(r_cal_length) > LEN_W'(CAL_DEPTH)) begin
            w_len = LEN_W'(CAL_DEPTH);
        end else begin
            w_len = LEN_W'(r_cal_length);
        end
        // A stale position past the length in use restarts at entry zero
        w_pos     = (LEN_W'(r_cal_pos) < w_len) ? LEN_W'(r_cal_pos) : '0;
        w_pos_inc = w_pos + LEN_W'(1);

        w_since_inc   = (r_since != '1) ? r_since + 32'd1 : r_since;
        w_timeout     = w_since_inc >= r_max_interval;
        // Quarter the variance per earlier timeout
        w_shift       = {r_timeouts, 1'b0};
        w_var_shifted = w_shift[5] ? 32'd0 : (r_variance >> w_shift[4:0]);

        w_wr_idx = LEN_W'(i_cal_index);
        w_tab_we = w_in_accept && (i_func == FUNC_CAL_WRITE)
                   && (w_wr_idx < LEN_W'(CAL_DEPTH));
    end

    assign w_div_start = w_in_accept && (i_func == FUNC_STEP) && w_rising && !w_overlong;

    always_comb begin
        n_state     = r_state;
        n_prev      = r_prev;
        n_now       = r_now;
        n_last_edge = r_last_edge;
        n_since     = r_since;
        n_timeouts  = r_timeouts;
        n_cal_pos   = r_cal_pos;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_vel   = r_out_vel;
        n_out_var   = r_out_var;
        n_out_time  = r_out_time;

        // Drop the estimate once the receiver takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept && (i_func == FUNC_STEP)) begin
                    n_now = w_now;
                    if (w_change) begin
                        n_prev     = i_pin_level;
                        n_since    = '0;
                        n_timeouts = '0;
                        if (w_rising) begin
                            n_last_edge = w_now;
                            n_cal_pos   = (w_pos_inc >= w_len) ? '0
                                                               : w_pos_inc[CAL_IW-1:0];
                            n_out_var   = '0;
                            if (w_overlong) begin
                                n_out_valid = 1'b1;
                                n_out_kind  = KIND_OVERLONG;
                                n_out_vel   = r_min_vel_half;
                                n_out_time  = w_now - w_half_max;
                            end else begin
                                // Velocity follows from the serial units
                                n_state    = S_DIV;
                                n_out_kind = KIND_EDGE;
                                n_out_time = w_now - (w_interval >> 1);
                            end
                        end
                    end else if (w_timeout) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = KIND_TIMEOUT;
                        n_out_vel   = (r_timeouts == '0) ? r_min_vel_half : '0;
                        n_out_var   = w_var_shifted;
                        n_out_time  = w_now - w_half_max;
                        n_since     = '0;
                        if (r_timeouts != '1) begin
                            n_timeouts = r_timeouts + TOC_W'(1);
                        end
                    end else begin
                        n_since = w_since_inc;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (w_mul_done) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out_vel   = w_mul_vel;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= 1'b0;
            r_now       <= '0;
            r_last_edge <= '0;
            r_since     <= '0;
            r_timeouts  <= '0;
            r_cal_pos   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_now       <= n_now;
            r_last_edge <= n_last_edge;
            r_since     <= n_since;
            r_timeouts  <= n_timeouts;
            r_cal_pos   <= n_cal_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_vel  <= n_out_vel;
        r_out_var  <= n_out_var;
        r_out_time <= n_out_time;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_numerator    <= NUM_W'(65536);
            r_max_interval <= 32'd1000000;
            r_min_vel_half <= '0;
            r_variance     <= 32'd65536;
            r_cal_length   <= 5'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_NUMERATOR:  r_numerator    <= i_cfg_data;
                CFG_MAX_INTVL:  r_max_interval <= i_cfg_data[31:0];
                CFG_MIN_VEL:    r_min_vel_half <= i_cfg_data[VEL_W-1:0];
                CFG_VARIANCE:   r_variance     <= i_cfg_data[31:0];
                CFG_CAL_LENGTH: r_cal_length   <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // Calibration table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CAL_DEPTH; i++) begin
                r_cal_table[i] <= CAL_ONE;
            end
        end else if (w_tab_we) begin
            r_cal_table[w_wr_idx[CAL_IW-1:0]] <= i_cal_value;
        end
    end

    // Capture the factor for this edge as the divide starts
    always_ff @(posedge i_clk) begin
        if (w_div_start) begin
            r_cal_val <= r_cal_table[w_pos[CAL_IW-1:0]];
        end
    end

    epve_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_numerator (r_numerator),
        .i_divisor   (w_interval),
        .o_done      (w_div_done),
        .o_quotient  (w_quotient)
    );

    epve_multiplier u_multiplier (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_done),
        .i_raw      (w_quotient),
        .i_cal      (r_cal_val),
        .o_done     (w_mul_done),
        .o_velocity (w_mul_vel)
    );

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_velocity     = r_out_vel;
    assign o_variance_out = r_out_var;
    assign o_sample_time  = r_out_time;

    // The output register stays empty while an edge is being worked out
    a_slot_empty_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_MUL) |-> !r_out_valid)
        else $error("estimate pending during serial work");

    // Divider finishes only while the block waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider done outside divide phase");

    // A finished multiply shows up as an estimate in the next cycle
    a_mul_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mul_done && r_state == S_MUL) |=> (o_out_valid && o_kind == KIND_EDGE))
        else $error("multiply result not delivered");

    // A table write never produces an estimate
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_func == FUNC_CAL_WRITE) |=>
            (o_out_valid == ($past(o_out_valid) && $past(i_out_stall))))
        else $error("table write produced an estimate");

endmodule
